// ----- sv/sorted_count_order_keeper_unit_defines.svh -----
// Assertion macros for the sorted count order keeper.
`ifndef SORTED_COUNT_ORDER_KEEPER_UNIT_DEFINES_SVH
`define SORTED_COUNT_ORDER_KEEPER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define SCOK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition is followed by another one on the next edge.
`define SCOK_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SCOK_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCOK_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- sv/scok_pkg.sv -----
// Shared constants and types of the sorted count order keeper.
`default_nettype none
package scok_pkg;
  localparam int unsigned MAX_CLUSTERS = 64;
  localparam int unsigned MAX_SIZE     = 1023;
  localparam int unsigned CW           = 6;   // cluster index / rank
  localparam int unsigned NW           = 7;   // counts up to MAX_CLUSTERS
  localparam int unsigned SW           = 10;  // size value
  localparam int unsigned SD           = 1024;
  localparam logic [NW-1:0] RUN_EMPTY  = 7'h7F;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;
  localparam logic [1:0] ST_LABEL = 2'd3;

  typedef enum logic [3:0] {
    ACT_IDLE, ACT_LD_RD, ACT_LD_WR, ACT_CLR, ACT_BI_RD, ACT_BI_CAP, ACT_BJ,
    ACT_B_WR, ACT_RK_RD, ACT_RK_RUN, ACT_RK_NBR, ACT_RK_UPD, ACT_RK_SWAP, ACT_OUT
  } act_e;

  typedef struct packed {
    act_e act;
    logic take;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic built;
    logic last;
    logic clr_last;
    logic j_done;
    logic i_last;
    logic rk_bad;
    logic limit;
    logic edge_bad;
  } stat_t;
endpackage
`default_nettype wire

// ----- sv/scok_if.sv -----
// Valid/ready channel interfaces for input and result items.
`default_nettype none
interface scok_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [5:0] label;
  logic       last_label;
  logic [5:0] rank;
  modport source (output valid, op, label, last_label, rank, input ready);
  modport sink (input valid, op, label, last_label, rank, output ready);
endinterface

interface scok_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] moved_cluster;
  logic [5:0] new_rank;
  logic [9:0] new_size;
  logic [5:0] displaced_cluster;
  logic       order_ready;
  modport source (output valid, status, moved_cluster, new_rank, new_size,
                  displaced_cluster, order_ready, input ready);
  modport sink (input valid, status, moved_cluster, new_rank, new_size,
                displaced_cluster, order_ready, output ready);
endinterface
`default_nettype wire

// ----- sv/sorted_count_order_keeper_unit.sv -----
// Top level of the sorted count order keeper: sequencer plus datapath.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+-------------------------------------------
//   in_i     | in  | valid / ready  | op, label, last_label, rank
//   out_o    | out | valid / ready  | status, moved_cluster, new_rank, new_size,
//            |     |                | displaced_cluster, order_ready
//   cfg      | in  | cfg_we_i       | cfg_wdata_i (cluster_count)
//
// One item at a time. A load goes to its result register through a count read
// and a count write, an add or sub through a size read, run read, neighbor run
// read and two swap writes, each bound by the single read port of the tables;
// the sequencer then returns to idle, where the next item is taken. A rejected
// add or sub leaves early. A load flagged last_label also builds the order: a
// sweep over all 1024 entries that empties both run tables, then rank counting
// through the count memory. A result waits in the output register while the
// next item is taken; if it is still not taken when the next result is done,
// hold there.
// Reset and configuration writes clear the counts and the built order.
`default_nettype none
`include "sorted_count_order_keeper_unit_defines.svh"
module sorted_count_order_keeper_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  scok_in_if.sink         in_i,
  scok_out_if.source      out_o,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i
);
  scok_pkg::cmd_t  cmd;
  scok_pkg::stat_t stat;

  // Sequencer: owns the handshakes and steps through each item.
  scok_ctl u_ctl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.op),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: tables, counters and the output register.
  scok_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_op_i       (in_i.op),
    .in_label_i    (in_i.label),
    .in_last_i     (in_i.last_label),
    .in_rank_i     (in_i.rank),
    .cfg_we_i,
    .cfg_wdata_i,
    .status_o      (out_o.status),
    .moved_o       (out_o.moved_cluster),
    .nrank_o       (out_o.new_rank),
    .nsize_o       (out_o.new_size),
    .disp_o        (out_o.displaced_cluster),
    .order_ready_o (out_o.order_ready)
  );

  // One item at a time: an accepted item closes the input for the next cycle.
  `SCOK_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready, "item overlap")
  // A nonzero new rank only comes from an add or sub on a built order.
  `SCOK_ASSERT(a_rank_built, clk_i, rst_ni, !(out_o.valid && out_o.new_rank != 6'd0) || out_o.order_ready, "rank without order")
  // A configuration write drops the built order.
  `SCOK_ASSERT_NEXT(a_cfg_clear, clk_i, rst_ni, cfg_we_i, !stat.built, "order kept over config")
endmodule
`default_nettype wire

// ----- sv/scok_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module scok_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);
  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- sv/scok_ctl.sv -----
// Sequencer: state machine that steps the datapath through each item.
`default_nettype none
module scok_ctl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    in_op_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire scok_pkg::stat_t stat_i,
  output scok_pkg::cmd_t     cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_LD_RD, S_LD_WR, S_CLR, S_BI_RD, S_BI_CAP, S_BJ, S_B_WR,
    S_RK_RD, S_RK_RUN, S_RK_NBR, S_RK_UPD, S_RK_SWAP, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   take, emit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign take        = in_valid_i && (state_q == S_IDLE);
  assign emit        = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = (in_op_i == scok_pkg::OP_LOAD) ? S_LD_RD : S_RK_RD;
        end
      end
      S_LD_RD:   state_d = S_LD_WR;
      S_LD_WR:   state_d = stat_i.last ? S_CLR : S_OUT;
      S_CLR:     state_d = stat_i.clr_last ? S_BI_RD : S_CLR;
      S_BI_RD:   state_d = S_BI_CAP;
      S_BI_CAP:  state_d = S_BJ;
      S_BJ:      state_d = stat_i.j_done ? S_B_WR : S_BJ;
      S_B_WR:    state_d = stat_i.i_last ? S_OUT : S_BI_RD;
      S_RK_RD:   state_d = stat_i.rk_bad ? S_OUT : S_RK_RUN;
      S_RK_RUN:  state_d = stat_i.limit ? S_OUT : S_RK_NBR;
      S_RK_NBR:  state_d = stat_i.edge_bad ? S_OUT : S_RK_UPD;
      S_RK_UPD:  state_d = S_RK_SWAP;
      S_RK_SWAP: state_d = S_OUT;
      S_OUT:     state_d = emit ? S_IDLE : S_OUT;
      default:   state_d = S_IDLE;
    endcase
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_comb begin
    cmd_o.take = take;
    cmd_o.emit = emit;
    case (state_q)
      S_IDLE:    cmd_o.act = scok_pkg::ACT_IDLE;
      S_LD_RD:   cmd_o.act = scok_pkg::ACT_LD_RD;
      S_LD_WR:   cmd_o.act = scok_pkg::ACT_LD_WR;
      S_CLR:     cmd_o.act = scok_pkg::ACT_CLR;
      S_BI_RD:   cmd_o.act = scok_pkg::ACT_BI_RD;
      S_BI_CAP:  cmd_o.act = scok_pkg::ACT_BI_CAP;
      S_BJ:      cmd_o.act = scok_pkg::ACT_BJ;
      S_B_WR:    cmd_o.act = scok_pkg::ACT_B_WR;
      S_RK_RD:   cmd_o.act = scok_pkg::ACT_RK_RD;
      S_RK_RUN:  cmd_o.act = scok_pkg::ACT_RK_RUN;
      S_RK_NBR:  cmd_o.act = scok_pkg::ACT_RK_NBR;
      S_RK_UPD:  cmd_o.act = scok_pkg::ACT_RK_UPD;
      S_RK_SWAP: cmd_o.act = scok_pkg::ACT_RK_SWAP;
      S_OUT:     cmd_o.act = scok_pkg::ACT_OUT;
      default:   cmd_o.act = scok_pkg::ACT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

// ----- sv/scok_dp.sv -----
// Datapath: count, order and run tables, loop counters and result registers.
`default_nettype none
module scok_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire scok_pkg::cmd_t   cmd_i,
  output scok_pkg::stat_t       stat_o,
  input  wire logic [1:0]       in_op_i,
  input  wire logic [5:0]       in_label_i,
  input  wire logic             in_last_i,
  input  wire logic [5:0]       in_rank_i,
  input  wire logic             cfg_we_i,
  input  wire logic [6:0]       cfg_wdata_i,
  output logic [1:0]            status_o,
  output logic [5:0]            moved_o,
  output logic [5:0]            nrank_o,
  output logic [9:0]            nsize_o,
  output logic [5:0]            disp_o,
  output logic                  order_ready_o
);
  localparam int unsigned CW = scok_pkg::CW;
  localparam int unsigned NW = scok_pkg::NW;
  localparam int unsigned SW = scok_pkg::SW;
  localparam logic [SW-1:0] SMAX = SW'(scok_pkg::MAX_SIZE);
  localparam logic [NW-1:0] EMPTY = scok_pkg::RUN_EMPTY;

  scok_pkg::act_e act;
  assign act = cmd_i.act;

  // captured item and configuration
  logic [1:0]    op_q;
  logic [CW-1:0] label_q, rank_q;
  logic          last_q;
  logic [NW-1:0] cc_q;
  logic          built_q;
  logic [scok_pkg::MAX_CLUSTERS-1:0] vld_q;
  logic          vld_rd_q;

  // loop state
  logic [SW-1:0] clr_q;
  logic [CW-1:0] i_q;
  logic [NW-1:0] j_q;
  logic [CW-1:0] jprev_q;
  logic          pend_q;
  logic [SW-1:0] ci_q;
  logic [NW-1:0] lt_q, eq_q, bef_q;

  // rank update state
  logic [SW-1:0] s_q, n_q;
  logic [CW-1:0] edge_q, ca_rank_q;

  // results
  logic [1:0]    res_st_q;
  logic [CW-1:0] res_mv_q, res_nr_q, res_dp_q;
  logic [SW-1:0] res_ns_q;

  // memories
  logic          cnt_we, size_we, ca_we, run_we;
  logic [CW-1:0] cnt_raddr, size_waddr, ca_raddr, ca_waddr;
  logic [SW-1:0] cnt_wdata, cnt_rdata, size_wdata, size_rdata;
  logic [SW-1:0] run_waddr, run_raddr;
  logic [CW-1:0] ca_wdata, ca_rdata;
  logic [NW-1:0] runf_wdata, runl_wdata, runf_rdata, runl_rdata;

  logic          label_ok, rank_ok, add, cnt_lim, issue, ok_nbr, single;
  logic [SW-1:0] cv, n_c;
  logic [NW-1:0] edge_c, r_c, last_c;

  assign add      = (op_q == scok_pkg::OP_ADD);
  assign label_ok = {1'b0, label_q} < cc_q;
  assign rank_ok  = {1'b0, rank_q} < cc_q;
  assign cv       = vld_rd_q ? cnt_rdata : '0;
  assign cnt_lim  = (cv >= SMAX);
  assign issue    = (j_q < cc_q);
  assign r_c      = lt_q + bef_q;
  assign last_c   = lt_q + eq_q - NW'(1);
  assign edge_c   = add ? runl_rdata : runf_rdata;
  assign ok_nbr   = (edge_c < cc_q);
  assign single   = add ? (edge_c == runf_rdata) : (edge_c == runl_rdata);
  assign n_c      = add ? (s_q + SW'(1)) : (s_q - SW'(1));

  assign stat_o.built    = built_q;
  assign stat_o.last     = last_q;
  assign stat_o.clr_last = &clr_q;
  assign stat_o.j_done   = !issue && !pend_q;
  assign stat_o.i_last   = ({1'b0, i_q} == (cc_q - NW'(1)));
  assign stat_o.rk_bad   = (op_q == scok_pkg::OP_NONE) || !built_q || !rank_ok;
  assign stat_o.limit    = add ? (size_rdata >= SMAX) : (size_rdata == '0);
  assign stat_o.edge_bad = !ok_nbr;

  always_comb begin
    cnt_raddr = j_q[CW-1:0];
    if (act == scok_pkg::ACT_LD_RD) begin
      cnt_raddr = label_q;
    end else if (act == scok_pkg::ACT_BI_RD) begin
      cnt_raddr = i_q;
    end
    cnt_we    = (act == scok_pkg::ACT_LD_WR) && label_ok && !cnt_lim;
    cnt_wdata = cv + SW'(1);

    size_we    = 1'b0;
    size_waddr = r_c[CW-1:0];
    size_wdata = ci_q;
    ca_we      = 1'b0;
    ca_waddr   = r_c[CW-1:0];
    ca_wdata   = i_q;
    ca_raddr   = (act == scok_pkg::ACT_RK_NBR) ? edge_c[CW-1:0] : rank_q;
    run_we     = 1'b0;
    run_waddr  = clr_q;
    runf_wdata = EMPTY;
    runl_wdata = EMPTY;
    run_raddr  = (act == scok_pkg::ACT_RK_NBR) ? n_c : size_rdata;

    case (act)
      scok_pkg::ACT_CLR: begin
        run_we = 1'b1;
      end
      scok_pkg::ACT_B_WR: begin
        size_we    = 1'b1;
        ca_we      = 1'b1;
        run_we     = 1'b1;
        run_waddr  = ci_q;
        runf_wdata = lt_q;
        runl_wdata = last_c;
      end
      scok_pkg::ACT_RK_NBR: begin
        size_we    = ok_nbr;
        size_waddr = edge_c[CW-1:0];
        size_wdata = n_c;
        run_we     = ok_nbr;
        run_waddr  = s_q;
        if (single) begin
          runf_wdata = EMPTY;
          runl_wdata = EMPTY;
        end else if (add) begin
          runf_wdata = runf_rdata;
          runl_wdata = edge_c - NW'(1);
        end else begin
          runf_wdata = edge_c + NW'(1);
          runl_wdata = runl_rdata;
        end
      end
      scok_pkg::ACT_RK_UPD: begin
        ca_we     = 1'b1;
        ca_waddr  = rank_q;
        ca_wdata  = ca_rdata;
        run_we    = 1'b1;
        run_waddr = n_q;
        if (add) begin
          runf_wdata = {1'b0, edge_q};
          runl_wdata = (runl_rdata == EMPTY) ? {1'b0, edge_q} : runl_rdata;
        end else begin
          runl_wdata = {1'b0, edge_q};
          runf_wdata = (runf_rdata == EMPTY) ? {1'b0, edge_q} : runf_rdata;
        end
      end
      scok_pkg::ACT_RK_SWAP: begin
        ca_we    = 1'b1;
        ca_waddr = edge_q;
        ca_wdata = ca_rank_q;
      end
      default: begin
      end
    endcase
  end

  scok_ram #(.W(SW), .D(scok_pkg::MAX_CLUSTERS)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(label_q), .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rdata));
  scok_ram #(.W(SW), .D(scok_pkg::MAX_CLUSTERS)) u_size (
    .clk_i, .we_i(size_we), .waddr_i(size_waddr), .wdata_i(size_wdata),
    .raddr_i(rank_q), .rdata_o(size_rdata));
  scok_ram #(.W(CW), .D(scok_pkg::MAX_CLUSTERS)) u_ca (
    .clk_i, .we_i(ca_we), .waddr_i(ca_waddr), .wdata_i(ca_wdata),
    .raddr_i(ca_raddr), .rdata_o(ca_rdata));
  scok_ram #(.W(NW), .D(scok_pkg::SD)) u_runf (
    .clk_i, .we_i(run_we), .waddr_i(run_waddr), .wdata_i(runf_wdata),
    .raddr_i(run_raddr), .rdata_o(runf_rdata));
  scok_ram #(.W(NW), .D(scok_pkg::SD)) u_runl (
    .clk_i, .we_i(run_we), .waddr_i(run_waddr), .wdata_i(runl_wdata),
    .raddr_i(run_raddr), .rdata_o(runl_rdata));

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q    <= NW'(scok_pkg::MAX_CLUSTERS);
      built_q <= 1'b0;
      vld_q   <= '0;
      pend_q  <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        cc_q <= NW'(1);
      end else if (cfg_wdata_i > NW'(scok_pkg::MAX_CLUSTERS)) begin
        cc_q <= NW'(scok_pkg::MAX_CLUSTERS);
      end else begin
        cc_q <= cfg_wdata_i;
      end
      built_q <= 1'b0;
      vld_q   <= '0;
    end else begin
      case (act)
        scok_pkg::ACT_LD_RD: begin
          if (built_q) begin
            built_q <= 1'b0;
            vld_q   <= '0;
          end
        end
        scok_pkg::ACT_LD_WR: begin
          if (cnt_we) begin
            vld_q[label_q] <= 1'b1;
          end
        end
        scok_pkg::ACT_BI_CAP: pend_q <= 1'b0;
        scok_pkg::ACT_BJ:     pend_q <= issue;
        scok_pkg::ACT_B_WR: begin
          if (stat_o.i_last) begin
            built_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (act)
      scok_pkg::ACT_IDLE: begin
        if (cmd_i.take) begin
          op_q    <= in_op_i;
          label_q <= in_label_i;
          last_q  <= in_last_i;
          rank_q  <= in_rank_i;
        end
      end
      scok_pkg::ACT_LD_RD: vld_rd_q <= !built_q && vld_q[label_q];
      scok_pkg::ACT_LD_WR: begin
        clr_q    <= '0;
        i_q      <= '0;
        res_mv_q <= label_q;
        res_nr_q <= '0;
        res_dp_q <= '0;
        if (!label_ok) begin
          res_st_q <= scok_pkg::ST_LABEL;
          res_ns_q <= '0;
        end else if (cnt_lim) begin
          res_st_q <= scok_pkg::ST_LIMIT;
          res_ns_q <= cv;
        end else begin
          res_st_q <= scok_pkg::ST_OK;
          res_ns_q <= cnt_wdata;
        end
      end
      scok_pkg::ACT_CLR:   clr_q <= clr_q + SW'(1);
      scok_pkg::ACT_BI_RD: vld_rd_q <= vld_q[i_q];
      scok_pkg::ACT_BI_CAP: begin
        ci_q  <= cv;
        j_q   <= '0;
        lt_q  <= '0;
        eq_q  <= '0;
        bef_q <= '0;
      end
      scok_pkg::ACT_BJ: begin
        if (pend_q) begin
          if (cv < ci_q) begin
            lt_q <= lt_q + NW'(1);
          end
          if (cv == ci_q) begin
            eq_q <= eq_q + NW'(1);
            if (jprev_q < i_q) begin
              bef_q <= bef_q + NW'(1);
            end
          end
        end
        if (issue) begin
          vld_rd_q <= vld_q[j_q[CW-1:0]];
          jprev_q  <= j_q[CW-1:0];
          j_q      <= j_q + NW'(1);
        end
      end
      scok_pkg::ACT_B_WR: i_q <= i_q + CW'(1);
      scok_pkg::ACT_RK_RD: begin
        res_st_q <= scok_pkg::ST_BAD;
        res_mv_q <= '0;
        res_nr_q <= '0;
        res_ns_q <= '0;
        res_dp_q <= '0;
      end
      scok_pkg::ACT_RK_RUN: begin
        s_q      <= size_rdata;
        res_st_q <= scok_pkg::ST_LIMIT;
      end
      scok_pkg::ACT_RK_NBR: begin
        n_q       <= n_c;
        edge_q    <= edge_c[CW-1:0];
        ca_rank_q <= ca_rdata;
        res_st_q  <= scok_pkg::ST_BAD;
      end
      scok_pkg::ACT_RK_UPD: begin
        res_st_q <= scok_pkg::ST_OK;
        res_mv_q <= ca_rank_q;
        res_nr_q <= edge_q;
        res_ns_q <= n_q;
        res_dp_q <= ca_rdata;
      end
      default: begin
      end
    endcase
    if (cmd_i.emit) begin
      status_o      <= res_st_q;
      moved_o       <= res_mv_q;
      nrank_o       <= res_nr_q;
      nsize_o       <= res_ns_q;
      disp_o        <= res_dp_q;
      order_ready_o <= built_q;
    end
  end
endmodule
`default_nettype wire
